### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion wrappers used by the decoder top level.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_CLK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_CLK_ALWAYS(lbl, prop, msg)
`endif
`endif

### rtl/av1dd_pkg.sv
// ----------------------------------------------------------------------------
// AV1 descriptor decoder package
// Descriptor codes, field widths and the result word type.
// ----------------------------------------------------------------------------
`default_nettype none

package av1dd_pkg;

  localparam int WindowBits = 64;
  localparam int CountBits  = 32;
  localparam int ValueBits  = 33;
  localparam int UsedBits   = 7;
  localparam int PhaseBits  = 3;

  localparam logic [31:0] AllOnes32 = 32'hffffffff;
  localparam logic [7:0]  Leb128Mask = 8'h7f;
  localparam int          MaxFieldBits = 32;
  localparam int          MaxLeBytes   = 4;

  typedef enum logic [2:0] {
    KIND_F      = 3'd0,
    KIND_UVLC   = 3'd1,
    KIND_LE     = 3'd2,
    KIND_LEB128 = 3'd3,
    KIND_SU     = 3'd4,
    KIND_NS     = 3'd5,
    KIND_ALIGN  = 3'd6
  } kind_t;

  // The value is two's complement for su and unsigned for the others.
  typedef struct packed {
    logic [ValueBits-1:0] value;
    logic [UsedBits-1:0]  bits_used;
    logic                 fault;
  } result_t;

endpackage

`default_nettype wire

### rtl/av1dd_decode.sv
// ----------------------------------------------------------------------------
// AV1 descriptor decode logic
// Decodes one descriptor from the look-ahead window in a single pass.
// ----------------------------------------------------------------------------
`default_nettype none

module av1dd_decode (
  input  wire logic [2:0]                       kind,
  input  wire logic [av1dd_pkg::CountBits-1:0]  count,
  input  wire logic [av1dd_pkg::WindowBits-1:0] bit_window,
  input  wire logic [av1dd_pkg::PhaseBits-1:0]  bit_phase,
  output av1dd_pkg::result_t                    res
);
  import av1dd_pkg::*;

  logic [31:0]           top32;
  logic                  count_gt32;
  logic                  count_gt4;
  logic [5:0]            nbits;

  logic [31:0]           f_value;

  logic [6:0]            lz;
  logic [63:0]           uv_shift;
  logic [63:0]           uv_bits;
  logic [32:0]           uv_sum;
  logic [31:0]           uv_value;
  logic [6:0]            uv_used;

  logic [31:0]           le_value;

  logic [63:0]           leb_acc;
  logic [6:0]            leb_used;
  logic                  leb_more;

  logic                  su_sign;
  logic [32:0]           su_value;

  logic [4:0]            flog;
  logic [5:0]            ns_w;
  logic [31:0]           ns_v;
  logic [32:0]           ns_m;
  logic                  ns_short;
  logic                  ns_extra;
  logic [32:0]           ns_value;

  always_comb begin
    top32      = bit_window[WindowBits-1 -: 32];
    count_gt32 = (count > CountBits'(MaxFieldBits));
    count_gt4  = (count > CountBits'(MaxLeBytes));
    nbits      = count[5:0];
    f_value    = top32 >> (6'd32 - nbits);
  end

  always_comb begin
    lz = 7'd64;
    for (int i = 0; i < WindowBits; i++) begin
      if (bit_window[i]) begin
        lz = 7'(63 - i);
      end
    end
    uv_shift = bit_window << (lz + 7'd1);
    uv_bits  = uv_shift >> (7'd64 - lz);
    uv_sum   = {1'b0, uv_bits[31:0]} + (33'd1 << lz[4:0]) - 33'd1;
    if (lz >= 7'd32) begin
      uv_value = AllOnes32;
      uv_used  = lz + 7'd1;
    end else begin
      uv_value = uv_sum[31:0];
      uv_used  = {lz[5:0], 1'b1};
    end
  end

  always_comb begin
    le_value = '0;
    for (int i = 0; i < MaxLeBytes; i++) begin
      if (3'(i) < count[2:0]) begin
        le_value[8*i +: 8] = bit_window[WindowBits-1-8*i -: 8];
      end
    end
  end

  always_comb begin
    leb_acc  = '0;
    leb_used = '0;
    leb_more = 1'b1;
    for (int i = 0; i < 8; i++) begin
      if (leb_more) begin
        leb_acc  = leb_acc
                 | (64'(bit_window[WindowBits-1-8*i -: 8] & Leb128Mask) << (7*i));
        leb_used = leb_used + 7'd8;
        leb_more = bit_window[WindowBits-1-8*i];
      end
    end
  end

  always_comb begin
    su_sign  = (nbits != 6'd0) && ((f_value & (32'd1 << (nbits - 6'd1))) != 32'd0);
    su_value = {1'b0, f_value} - (su_sign ? (33'd1 << nbits) : 33'd0);
  end

  always_comb begin
    flog = '0;
    for (int i = 0; i < CountBits; i++) begin
      if (count[i]) begin
        flog = 5'(i);
      end
    end
    ns_w     = {1'b0, flog} + 6'd1;
    ns_v     = top32 >> (6'd32 - {1'b0, flog});
    ns_m     = (33'd1 << ns_w) - {1'b0, count};
    ns_short = ({1'b0, ns_v} < ns_m);
    ns_extra = bit_window[6'(6'd63 - {1'b0, flog})];
    ns_value = {ns_v, 1'b0} - ns_m + {32'd0, ns_extra};
  end

  always_comb begin
    res = '0;
    unique case (kind)
      KIND_F: begin
        if (count_gt32) begin
          res.fault = 1'b1;
        end else begin
          res.value     = {1'b0, f_value};
          res.bits_used = {1'b0, nbits};
        end
      end
      KIND_UVLC: begin
        if (lz == 7'd64) begin
          res.fault = 1'b1;
        end else begin
          res.value     = {1'b0, uv_value};
          res.bits_used = uv_used;
        end
      end
      KIND_LE: begin
        if (count_gt4) begin
          res.fault = 1'b1;
        end else begin
          res.value     = {1'b0, le_value};
          res.bits_used = {count[2:0], 3'd0} + 7'd0;
        end
      end
      KIND_LEB128: begin
        res.value     = {1'b0, leb_acc[31:0]};
        res.bits_used = leb_used;
      end
      KIND_SU: begin
        if (count_gt32) begin
          res.fault = 1'b1;
        end else begin
          res.value     = su_value;
          res.bits_used = {1'b0, nbits};
        end
      end
      KIND_NS: begin
        if (count == '0) begin
          res.fault = 1'b1;
        end else if (ns_short) begin
          res.value     = {1'b0, ns_v};
          res.bits_used = {2'd0, flog};
        end else begin
          res.value     = ns_value;
          res.bits_used = {1'b0, ns_w};
        end
      end
      KIND_ALIGN: begin
        res.bits_used = {4'd0, 3'(3'd0 - bit_phase)};
      end
      default: begin
        res.fault = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/av1_descriptor_decoder.sv
// ----------------------------------------------------------------------------
// AV1 descriptor decoder
// An accepted word goes from the input register through decode to the result
// register. Throughput: one word per cycle unless the output stalls, set by the
// single decode pass between the input and result registers.
// Reset clears the valid flags and the bit phase; payload is not reset.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module av1_descriptor_decoder (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // Fields from bit 0: count[31:0], bit_window[63:0].
  input  wire logic [95:0] s_tdata,
  // Fields from bit 0: kind[2:0].
  input  wire logic [2:0]  s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // Fields from bit 0: value[32:0], bits_used[6:0].
  output logic [39:0]      m_tdata,
  // Fields from bit 0: fault.
  output logic             m_tuser
);
  import av1dd_pkg::*;

  logic                  in_valid;
  logic [2:0]            in_kind;
  logic [CountBits-1:0]  in_count;
  logic [WindowBits-1:0] in_window;
  logic [PhaseBits-1:0]  bit_phase;
  logic                  advance;
  logic                  load;
  result_t               dec;
  result_t               out_res;

  assign advance  = !m_tvalid || m_tready;
  assign load     = in_valid && advance;
  assign s_tready = !in_valid || advance;

  av1dd_decode u_decode (
    .kind       (in_kind),
    .count      (in_count),
    .bit_window (in_window),
    .bit_phase  (bit_phase),
    .res        (dec)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_kind   <= s_tuser;
      in_count  <= s_tdata[CountBits-1:0];
      in_window <= s_tdata[CountBits +: WindowBits];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid  <= 1'b0;
      bit_phase <= '0;
    end else if (load) begin
      m_tvalid <= 1'b1;
      if (!dec.fault) begin
        bit_phase <= bit_phase + dec.bits_used[PhaseBits-1:0];
      end
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res <= dec;
    end
  end

  assign m_tdata = {out_res.bits_used, out_res.value};
  assign m_tuser = out_res.fault;

  `ASSERT_CLK_ALWAYS(a_reset_clears_out, rst |=> !m_tvalid, "output valid after reset")
  `ASSERT_CLK(a_fault_zero, (m_tvalid && out_res.fault) |-> (m_tdata == 40'd0), "fault with data")
  `ASSERT_CLK(a_used_range, m_tvalid |-> (out_res.bits_used <= 7'd64), "bits_used beyond window")
  `ASSERT_CLK(a_align_phase, (load && in_kind == KIND_ALIGN) |=> (bit_phase == 3'd0), "align missed")

endmodule

`default_nettype wire

### dv/tb_av1_descriptor_decoder.sv
// ----------------------------------------------------------------------------
// AV1 descriptor decoder testbench
// A directed table of descriptors is followed by random descriptors of every
// kind, with random idle cycles on both sides. Each result word is checked
// against a typed row's result, else an in-bench decoder tracking bit phase.
// ----------------------------------------------------------------------------

module tb_av1_descriptor_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  import av1dd_pkg::*;

  localparam logic [2:0] KindUnused   = 3'd7;
  localparam int         RandomWords  = 1800;
  localparam int         SteadyFirst  = 700;
  localparam int         SteadyLast   = 1100;
  localparam int         IdlePercent  = 23;
  localparam int         StallLimit   = 2000;
  localparam int         DrainCycles  = 10;
  localparam int         ReportLimit  = 10;
  localparam logic [63:0] Ones64      = 64'hffff_ffff_ffff_ffff;

  localparam result_t NothingUsed = '0;
  localparam result_t FaultResult = '{value: '0, bits_used: '0, fault: 1'b1};

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] count;
    logic [63:0] window;
    logic        typed;
    result_t     want;
  } descriptor_row_t;

  localparam int DirectedRows = 26;
  localparam descriptor_row_t DirectedTable [DirectedRows] = '{
    '{KIND_ALIGN,  32'd0,          64'h0123_4567_89ab_cdef, 1'b1, NothingUsed},
    '{KIND_F,      32'd0,          Ones64,                  1'b1, NothingUsed},
    '{KIND_F,      32'd32,         Ones64,                  1'b1,
      '{33'h0_ffff_ffff, 7'd32, 1'b0}},
    '{KIND_F,      32'd33,         64'h5a5a_a5a5_0f0f_f0f0, 1'b1, FaultResult},
    '{KIND_F,      32'hffff_ffff,  Ones64,                  1'b1, FaultResult},
    '{KIND_UVLC,   32'd0,          64'd0,                   1'b1, FaultResult},
    '{KIND_UVLC,   32'hffff_ffff,  64'h8000_0000_0000_0000, 1'b1, '{33'd0, 7'd1, 1'b0}},
    '{KIND_UVLC,   32'd0,          64'd1,                   1'b1,
      '{33'h0_ffff_ffff, 7'd64, 1'b0}},
    '{KIND_UVLC,   32'd0,          64'h0000_0000_8000_0000, 1'b1,
      '{33'h0_ffff_ffff, 7'd33, 1'b0}},
    '{KIND_UVLC,   32'd0,          64'h0000_0001_ffff_ffff, 1'b0, NothingUsed},
    '{KIND_LE,     32'd0,          64'hdead_beef_cafe_f00d, 1'b1, NothingUsed},
    '{KIND_LE,     32'd4,          64'h1122_3344_5566_7788, 1'b0, NothingUsed},
    '{KIND_LE,     32'd5,          64'h1122_3344_5566_7788, 1'b1, FaultResult},
    '{KIND_LEB128, 32'd0,          Ones64,                  1'b0, NothingUsed},
    '{KIND_LEB128, 32'hffff_ffff,  64'h0012_3456_789a_bcde, 1'b1, '{33'd0, 7'd8, 1'b0}},
    '{KIND_LEB128, 32'd0,          64'h8081_8283_8405_0000, 1'b0, NothingUsed},
    '{KIND_SU,     32'd0,          Ones64,                  1'b1, NothingUsed},
    '{KIND_SU,     32'd32,         64'h8000_0000_0000_0000, 1'b1,
      '{33'h1_8000_0000, 7'd32, 1'b0}},
    '{KIND_SU,     32'd1,          64'h8000_0000_0000_0000, 1'b1,
      '{33'h1_ffff_ffff, 7'd1, 1'b0}},
    '{KIND_SU,     32'd33,         Ones64,                  1'b1, FaultResult},
    '{KIND_NS,     32'd0,          Ones64,                  1'b1, FaultResult},
    '{KIND_NS,     32'd1,          Ones64,                  1'b0, NothingUsed},
    '{KIND_NS,     32'hffff_ffff,  Ones64,                  1'b0, NothingUsed},
    '{KIND_NS,     32'd5,          64'hc000_0000_0000_0000, 1'b0, NothingUsed},
    '{KIND_ALIGN,  32'hffff_ffff,  64'h0f0f_0f0f_0f0f_0f0f, 1'b0, NothingUsed},
    '{KindUnused,  32'd3,          Ones64,                  1'b1, FaultResult}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [95:0] s_tdata = '0;
  logic [2:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        m_tuser;

  result_t     pending_results[$];
  logic [2:0]  stream_phase = '0;
  bit          steady = 1'b0;
  int          mismatch_count = 0;
  int          stall_cycles = 0;
  result_t     seen_result;
  result_t     oldest_result;

  av1_descriptor_decoder u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [63:0] window_bits(logic [63:0] win, int unsigned pos,
                                              int unsigned width);
    if (width == 0 || pos >= WindowBits) return '0;
    return (win << pos) >> (WindowBits - width);
  endfunction

  // Decodes one descriptor and advances the stream phase unless it faults.
  function automatic result_t decode_descriptor(logic [2:0] kind, logic [31:0] count,
                                                logic [63:0] win);
    logic [63:0] acc, v, sign_bit, span, octet;
    int unsigned used, zeros, width;
    logic        flt;
    result_t     res;
    acc  = '0;
    used = 0;
    flt  = 1'b0;
    case (kind)
      KIND_F: begin
        if (count > MaxFieldBits) begin
          flt = 1'b1;
        end else begin
          used = count;
          acc  = window_bits(win, 0, used);
        end
      end
      KIND_UVLC: begin
        if (win == '0) begin
          flt = 1'b1;
        end else begin
          zeros = 0;
          while (!win[63 - zeros]) zeros++;
          if (zeros >= 32) begin
            acc  = AllOnes32;
            used = zeros + 1;
          end else begin
            v    = window_bits(win, zeros + 1, zeros);
            acc  = (v + (64'd1 << zeros) - 64'd1) & 64'hffff_ffff;
            used = 2 * zeros + 1;
          end
        end
      end
      KIND_LE: begin
        if (count > MaxLeBytes) begin
          flt = 1'b1;
        end else begin
          for (int i = 0; i < count; i++) acc |= window_bits(win, 8 * i, 8) << (8 * i);
          used = 8 * count;
        end
      end
      KIND_LEB128: begin
        for (int i = 0; i < 8; i++) begin
          octet = window_bits(win, 8 * i, 8);
          acc  |= (octet & Leb128Mask) << (7 * i);
          used += 8;
          if (!octet[7]) break;
        end
        acc &= 64'hffff_ffff;
      end
      KIND_SU: begin
        if (count > MaxFieldBits) begin
          flt = 1'b1;
        end else begin
          used = count;
          if (used > 0) begin
            v        = window_bits(win, 0, used);
            sign_bit = 64'd1 << (used - 1);
            if ((v & sign_bit) != '0) v = v - 2 * sign_bit;
            acc = v;
          end
        end
      end
      KIND_NS: begin
        if (count == '0) begin
          flt = 1'b1;
        end else begin
          width = 0;
          for (int b = 0; b < CountBits; b++) if (count[b]) width = b + 1;
          span = (64'd1 << width) - count;
          v    = window_bits(win, 0, width - 1);
          if (v < span) begin
            acc  = v;
            used = width - 1;
          end else begin
            acc  = (v << 1) - span + window_bits(win, width - 1, 1);
            used = width;
          end
        end
      end
      KIND_ALIGN: used = (8 - stream_phase) & 7;
      default: flt = 1'b1;
    endcase
    if (flt) begin
      acc  = '0;
      used = 0;
    end else begin
      stream_phase = stream_phase + 3'(used);
    end
    res.value     = acc[ValueBits-1:0];
    res.bits_used = 7'(used);
    res.fault     = flt;
    return res;
  endfunction

  task automatic offer_word(logic [2:0] kind, logic [31:0] count, logic [63:0] win,
                            logic typed, result_t want);
    result_t predicted;
    while (!steady && $urandom_range(0, 99) < IdlePercent) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {win, count};
    s_tuser  <= kind;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predicted = decode_descriptor(kind, count, win);
    pending_results.push_back(typed ? want : predicted);
  endtask

  task automatic draw_descriptor(output logic [2:0] kind, output logic [31:0] count,
                                 output logic [63:0] win);
    int unsigned len;
    win   = {$urandom, $urandom};
    count = $urandom;
    kind  = ($urandom_range(0, 99) < 3) ? KindUnused : 3'($urandom_range(0, 6));
    case (kind)
      KIND_F, KIND_SU: begin
        if ($urandom_range(0, 19) != 0) count = $urandom_range(0, MaxFieldBits);
      end
      KIND_LE: begin
        if ($urandom_range(0, 19) != 0) count = $urandom_range(0, MaxLeBytes);
      end
      KIND_UVLC: begin
        if ($urandom_range(0, 24) == 0) win = '0;
        else win = win >> $urandom_range(0, 63);
      end
      KIND_LEB128: begin
        len = $urandom_range(1, 9);
        for (int i = 0; i < 8; i++) win[63 - 8 * i] = (i + 1 < len);
      end
      KIND_NS: begin
        if ($urandom_range(0, 19) == 0) count = '0;
        else count = count >> $urandom_range(0, 31);
      end
      default: ;
    endcase
  endtask

  task automatic note_mismatch(string what, result_t want, result_t got);
    mismatch_count++;
    if (mismatch_count <= ReportLimit) begin
      $display("%0t: %s: expected value %h bits %0d fault %b, got value %h bits %0d fault %b",
               $realtime, what, want.value, want.bits_used, want.fault,
               got.value, got.bits_used, got.fault);
    end
  endtask

  always @(posedge clk) begin
    m_tready <= steady || $urandom_range(0, 99) >= IdlePercent;
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      seen_result.value     = m_tdata[32:0];
      seen_result.bits_used = m_tdata[39:33];
      seen_result.fault     = m_tuser;
      if (pending_results.size() == 0) begin
        note_mismatch("unexpected result word", NothingUsed, seen_result);
      end else begin
        oldest_result = pending_results.pop_front();
        if (seen_result.value !== oldest_result.value ||
            seen_result.bits_used !== oldest_result.bits_used ||
            seen_result.fault !== oldest_result.fault) begin
          note_mismatch("result word mismatch", oldest_result, seen_result);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    logic [2:0]  kind;
    logic [31:0] count;
    logic [63:0] win;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int i = 0; i < DirectedRows; i++) begin
      offer_word(DirectedTable[i].kind, DirectedTable[i].count, DirectedTable[i].window,
                 DirectedTable[i].typed, DirectedTable[i].want);
    end
    for (int i = 0; i < RandomWords; i++) begin
      steady = (i >= SteadyFirst && i < SteadyLast);
      draw_descriptor(kind, count, win);
      offer_word(kind, count, win, 1'b0, NothingUsed);
    end
    steady = 1'b0;
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/av1dd_pkg.sv
rtl/av1dd_decode.sv
rtl/av1_descriptor_decoder.sv
dv/tb_av1_descriptor_decoder.sv
